@@ hw/rtl/segment_intersection_point_top_assert.svh @@
// assertion macros shared by the checker files
`ifndef SEGMENT_INTERSECTION_POINT_TOP_ASSERT_SVH
`define SEGMENT_INTERSECTION_POINT_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SIP_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define SIP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hw/rtl/sip_pkg.sv @@
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types and constants of the segment intersection block.
// ----------------------------------------------------------------------------
package sip_pkg;

  typedef enum logic [1:0] {
    STATUS_HIT      = 2'd0,
    STATUS_PARALLEL = 2'd1,
    STATUS_OUTSIDE  = 2'd2
  } status_e;

  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned QUEUE_DEPTH = 4;

endpackage

@@ hw/rtl/sip_front.sv @@
// ----------------------------------------------------------------------------
// sip_front
// Accepts segment pairs, forms the determinant and both numerators, classifies.
// ----------------------------------------------------------------------------
module sip_front #(
  parameter int unsigned W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [8*W-1:0]        in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sip_pkg::status_e      status_o,
  output logic [2*W:0]          det_o,
  output logic [2*W:0]          rnum_o,
  output logic [W:0]            dax_o,
  output logic [W:0]            day_o,
  output logic [W-1:0]          sx_o,
  output logic [W-1:0]          sy_o
);
  import sip_pkg::*;

  localparam int unsigned DW = 2 * W + 2;
  localparam int unsigned MW = DW - 1;

  logic [3:0] v_q;
  logic       fen;

  assign fen        = !v_q[3] || out_ready_i;
  assign in_ready_o = fen;
  assign out_valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (fen) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  // stage 1: differences
  logic [W-1:0] p0, p1, p2, p3, p4, p5, p6, p7;
  assign p0 = in_data_i[0*W +: W];
  assign p1 = in_data_i[1*W +: W];
  assign p2 = in_data_i[2*W +: W];
  assign p3 = in_data_i[3*W +: W];
  assign p4 = in_data_i[4*W +: W];
  assign p5 = in_data_i[5*W +: W];
  assign p6 = in_data_i[6*W +: W];
  assign p7 = in_data_i[7*W +: W];

  logic signed [W:0] dax_d, day_d, dbx_d, dby_d, cx_d, cy_d;
  assign dax_d = $signed({p2[W-1], p2}) - $signed({p0[W-1], p0});
  assign day_d = $signed({p3[W-1], p3}) - $signed({p1[W-1], p1});
  assign dbx_d = $signed({p6[W-1], p6}) - $signed({p4[W-1], p4});
  assign dby_d = $signed({p7[W-1], p7}) - $signed({p5[W-1], p5});
  assign cx_d  = $signed({p4[W-1], p4}) - $signed({p0[W-1], p0});
  assign cy_d  = $signed({p5[W-1], p5}) - $signed({p1[W-1], p1});

  logic signed [W:0] dax1_q, day1_q, dbx1_q, dby1_q, cx1_q, cy1_q;
  logic [W-1:0]      sx1_q, sy1_q;

  always_ff @(posedge clk_i) begin
    if (fen) begin
      dax1_q <= dax_d;
      day1_q <= day_d;
      dbx1_q <= dbx_d;
      dby1_q <= dby_d;
      cx1_q  <= cx_d;
      cy1_q  <= cy_d;
      sx1_q  <= p0;
      sy1_q  <= p1;
    end
  end

  // stage 2: six cross products
  logic signed [DW-1:0] m0_d, m1_d, m2_d, m3_d, m4_d, m5_d;
  assign m0_d = day1_q * dbx1_q;
  assign m1_d = dax1_q * dby1_q;
  assign m2_d = cy1_q * dbx1_q;
  assign m3_d = cx1_q * dby1_q;
  assign m4_d = dax1_q * cy1_q;
  assign m5_d = day1_q * cx1_q;

  logic signed [DW-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [W:0]    dax2_q, day2_q;
  logic [W-1:0]         sx2_q, sy2_q;

  always_ff @(posedge clk_i) begin
    if (fen) begin
      m0_q   <= m0_d;
      m1_q   <= m1_d;
      m2_q   <= m2_d;
      m3_q   <= m3_d;
      m4_q   <= m4_d;
      m5_q   <= m5_d;
      dax2_q <= dax1_q;
      day2_q <= day1_q;
      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;
    end
  end

  // stage 3: determinant and numerators, exact in DW bits
  logic signed [DW-1:0] det3_q, rn3_q, tn3_q;
  logic signed [W:0]    dax3_q, day3_q;
  logic [W-1:0]         sx3_q, sy3_q;

  always_ff @(posedge clk_i) begin
    if (fen) begin
      det3_q <= m0_q - m1_q;
      rn3_q  <= m2_q - m3_q;
      tn3_q  <= m4_q - m5_q;
      dax3_q <= dax2_q;
      day3_q <= day2_q;
      sx3_q  <= sx2_q;
      sy3_q  <= sy2_q;
    end
  end

  // stage 4: both parameters strictly inside (0, 1)
  logic                 det_pos, r_ok, t_ok;
  status_e              status_d;
  logic signed [DW-1:0] det_abs, rn_abs;

  always_comb begin
    det_pos = !det3_q[DW-1];
    if (det_pos) begin
      r_ok = (rn3_q > 0) && (rn3_q < det3_q);
      t_ok = (tn3_q > 0) && (tn3_q < det3_q);
    end else begin
      r_ok = (rn3_q < 0) && (rn3_q > det3_q);
      t_ok = (tn3_q < 0) && (tn3_q > det3_q);
    end
    if (det3_q == '0) begin
      status_d = STATUS_PARALLEL;
    end else if (r_ok && t_ok) begin
      status_d = STATUS_HIT;
    end else begin
      status_d = STATUS_OUTSIDE;
    end
    det_abs = det_pos ? det3_q : -det3_q;
    rn_abs  = det_pos ? rn3_q : -rn3_q;
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      status_o <= status_d;
      det_o    <= det_abs[MW-1:0];
      rnum_o   <= rn_abs[MW-1:0];
      dax_o    <= dax3_q;
      day_o    <= day3_q;
      sx_o     <= sx3_q;
      sy_o     <= sy3_q;
    end
  end

endmodule

@@ hw/rtl/sip_fifo.sv @@
// ----------------------------------------------------------------------------
// sip_fifo
// Short queue between the classify front and the point back end.
// ----------------------------------------------------------------------------
module sip_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [AW-1:0]     wptr_q, rptr_q;
  logic [CW-1:0]     cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hw/rtl/sip_div.sv @@
// ----------------------------------------------------------------------------
// sip_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module sip_div #(
  parameter int unsigned W     = 32,
  parameter int unsigned MW    = 65,
  parameter int unsigned TAG_W = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [W+MW-1:0]   num_i,
  input  logic [MW-1:0]     den_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic [W-1:0]      quo_o,
  output logic [MW-1:0]     rem_o,
  output logic [MW-1:0]     den_o,
  output logic [TAG_W-1:0]  tag_o
);
  // numerator high part is below the divisor, so the quotient has W bits
  logic [MW-1:0]    rem_q [W+1];
  logic [W-1:0]     wrd_q [W+1];
  logic [MW-1:0]    den_q [W+1];
  logic [TAG_W-1:0] tag_q [W+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[W+MW-1:W];
      wrd_q[0] <= num_i[W-1:0];
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [MW:0] trial, diff;
    logic        ge;
    assign trial = {rem_q[k], wrd_q[k][W-1]};
    assign ge    = trial >= {1'b0, den_q[k]};
    assign diff  = trial - {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[MW-1:0] : trial[MW-1:0];
        wrd_q[k+1] <= {wrd_q[k][W-2:0], ge};
        den_q[k+1] <= den_q[k];
        tag_q[k+1] <= tag_q[k];
      end
    end
  end

  assign quo_o = wrd_q[W];
  assign rem_o = rem_q[W];
  assign den_o = den_q[W];
  assign tag_o = tag_q[W];

endmodule

@@ hw/rtl/sip_back.sv @@
// ----------------------------------------------------------------------------
// sip_back
// Scales segment A by r = rnum / det, rounds, and holds the result register.
// ----------------------------------------------------------------------------
module sip_back #(
  parameter int unsigned W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sip_pkg::status_e status_i,
  input  logic [2*W:0]     det_i,
  input  logic [2*W:0]     rnum_i,
  input  logic [W:0]       dax_i,
  input  logic [W:0]       day_i,
  input  logic [W-1:0]     sx_i,
  input  logic [W-1:0]     sy_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sip_pkg::status_e status_o,
  output logic [W-1:0]     hit_x_o,
  output logic [W-1:0]     hit_y_o
);
  import sip_pkg::*;

  localparam int unsigned MW    = 2 * W + 1;
  localparam int unsigned NW    = W + MW;
  localparam int unsigned NSTG  = W + 6;
  localparam int unsigned TAGX  = STATUS_W + 1 + W;
  localparam int unsigned TAGY  = 1 + W;

  logic [NSTG-1:0] v_q;
  logic            ben;

  assign ben         = !v_q[NSTG-1] || out_ready_i;
  assign in_ready_o  = ben;
  assign out_valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ben) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // b0: take from queue, split sign and magnitude of the A deltas
  logic [W:0] ndax, nday;
  assign ndax = -dax_i;
  assign nday = -day_i;

  status_e      st0_q;
  logic [MW-1:0] det0_q, rn0_q;
  logic [W-1:0] mx0_q, my0_q, sx0_q, sy0_q;
  logic         nx0_q, ny0_q;

  always_ff @(posedge clk_i) begin
    if (ben) begin
      st0_q  <= status_i;
      det0_q <= det_i;
      rn0_q  <= rnum_i;
      mx0_q  <= dax_i[W] ? ndax[W-1:0] : dax_i[W-1:0];
      my0_q  <= day_i[W] ? nday[W-1:0] : day_i[W-1:0];
      nx0_q  <= dax_i[W];
      ny0_q  <= day_i[W];
      sx0_q  <= sx_i;
      sy0_q  <= sy_i;
    end
  end

  // b1: partial products over the low and high halves of rnum
  status_e       st1_q;
  logic [MW-1:0] det1_q;
  logic [2*W-1:0] plx1_q, ply1_q;
  logic [2*W:0]  phx1_q, phy1_q;
  logic [W-1:0]  sx1_q, sy1_q;
  logic          nx1_q, ny1_q;

  always_ff @(posedge clk_i) begin
    if (ben) begin
      st1_q  <= st0_q;
      det1_q <= det0_q;
      plx1_q <= mx0_q * rn0_q[W-1:0];
      ply1_q <= my0_q * rn0_q[W-1:0];
      phx1_q <= mx0_q * rn0_q[MW-1:W];
      phy1_q <= my0_q * rn0_q[MW-1:W];
      nx1_q  <= nx0_q;
      ny1_q  <= ny0_q;
      sx1_q  <= sx0_q;
      sy1_q  <= sy0_q;
    end
  end

  // b2: sum partial products
  status_e       st2_q;
  logic [MW-1:0] det2_q;
  logic [NW-1:0] prx2_q, pry2_q;
  logic [W-1:0]  sx2_q, sy2_q;
  logic          nx2_q, ny2_q;

  always_ff @(posedge clk_i) begin
    if (ben) begin
      st2_q  <= st1_q;
      det2_q <= det1_q;
      prx2_q <= {phx1_q, {W{1'b0}}} + NW'(plx1_q);
      pry2_q <= {phy1_q, {W{1'b0}}} + NW'(ply1_q);
      nx2_q  <= nx1_q;
      ny2_q  <= ny1_q;
      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;
    end
  end

  logic [W-1:0]    qx, qy;
  logic [MW-1:0]   rx, ry, dden;
  logic [TAGX-1:0] tagx;
  logic [TAGY-1:0] tagy;

  sip_div #(.W(W), .MW(MW), .TAG_W(TAGX)) u_div_x (
    .clk_i (clk_i),
    .en_i  (ben),
    .num_i (prx2_q),
    .den_i (det2_q),
    .tag_i ({st2_q, nx2_q, sx2_q}),
    .quo_o (qx),
    .rem_o (rx),
    .den_o (dden),
    .tag_o (tagx)
  );

  sip_div #(.W(W), .MW(MW), .TAG_W(TAGY)) u_div_y (
    .clk_i (clk_i),
    .en_i  (ben),
    .num_i (pry2_q),
    .den_i (det2_q),
    .tag_i ({ny2_q, sy2_q}),
    .quo_o (qy),
    .rem_o (ry),
    .den_o (),
    .tag_o (tagy)
  );

  // r1: round half away from zero on the magnitude
  logic incx, incy;
  assign incx = {rx, 1'b0} >= {1'b0, dden};
  assign incy = {ry, 1'b0} >= {1'b0, dden};

  status_e      st4_q;
  logic [W-1:0] ox4_q, oy4_q, sx4_q, sy4_q;
  logic         nx4_q, ny4_q;

  always_ff @(posedge clk_i) begin
    if (ben) begin
      st4_q <= status_e'(tagx[TAGX-1 -: STATUS_W]);
      nx4_q <= tagx[W];
      sx4_q <= tagx[W-1:0];
      ny4_q <= tagy[W];
      sy4_q <= tagy[W-1:0];
      ox4_q <= qx + W'(incx);
      oy4_q <= qy + W'(incy);
    end
  end

  // r2: result register, zero point on a miss
  logic [W-1:0] hx_d, hy_d;

  always_comb begin
    hx_d = nx4_q ? (sx4_q - ox4_q) : (sx4_q + ox4_q);
    hy_d = ny4_q ? (sy4_q - oy4_q) : (sy4_q + oy4_q);
    if (st4_q != STATUS_HIT) begin
      hx_d = '0;
      hy_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben) begin
      status_o <= st4_q;
      hit_x_o  <= hx_d;
      hit_y_o  <= hy_d;
    end
  end

endmodule

@@ hw/rtl/segment_intersection_point_top.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_point_top
// Intersection point of two line segments by Cramer's rule, fixed point.
// ----------------------------------------------------------------------------
// usage
//   slave stream: one request per segment pair, eight signed coordinates in
//   s_axis_tdata_i. master stream: one result per request, in order, with the
//   status in m_axis_tuser_o and the point in m_axis_tdata_o.
// timing
//   one request per cycle sustained while m_axis_tready_i stays high. a
//   result passes through the front pipeline, the queue and the back end,
//   whose restoring divider spends one stage per quotient bit (COORD_BITS
//   stages) plus multiply and rounding stages.
// reset
//   clears all valid flags and the queue; nothing is in flight afterwards.
// stall
//   when m_axis_tready_i is low the back end holds, the 4-entry queue absorbs
//   the front pipeline, then s_axis_tready_o drops. no result is lost.
// ----------------------------------------------------------------------------
module segment_intersection_point_top #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_BITS-1:0]                    s_axis_tdata_i,
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  // hit_x, hit_y, zero padding
  output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_axis_tdata_o,
  // status
  output logic [1:0]                                 m_axis_tuser_o
);
  import sip_pkg::*;

  localparam int unsigned W     = COORD_BITS;
  localparam int unsigned MW    = 2 * W + 1;
  localparam int unsigned QW    = STATUS_W + 2 * MW + 2 * (W + 1) + 2 * W;
  localparam int unsigned OUT_W = ((2 * W + 7) / 8) * 8;

  logic          f_valid, f_ready;
  status_e       f_status;
  logic [MW-1:0] f_det, f_rnum;
  logic [W:0]    f_dax, f_day;
  logic [W-1:0]  f_sx, f_sy;

  sip_front #(.W(W)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .status_o    (f_status),
    .det_o       (f_det),
    .rnum_o      (f_rnum),
    .dax_o       (f_dax),
    .day_o       (f_day),
    .sx_o        (f_sx),
    .sy_o        (f_sy)
  );

  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;

  sip_fifo #(.DATA_W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_status, f_det, f_rnum, f_dax, f_day, f_sx, f_sy}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  status_e       b_status_in, b_status;
  logic [MW-1:0] b_det, b_rnum;
  logic [W:0]    b_dax, b_day;
  logic [W-1:0]  b_sx, b_sy, hit_x, hit_y;

  assign b_status_in = status_e'(q_data[QW-1 -: STATUS_W]);
  assign {b_det, b_rnum, b_dax, b_day, b_sx, b_sy} = q_data[QW-STATUS_W-1:0];

  sip_back #(.W(W)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .status_i    (b_status_in),
    .det_i       (b_det),
    .rnum_i      (b_rnum),
    .dax_i       (b_dax),
    .day_i       (b_day),
    .sx_i        (b_sx),
    .sy_i        (b_sy),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_o    (b_status),
    .hit_x_o     (hit_x),
    .hit_y_o     (hit_y)
  );

  assign m_axis_tdata_o = OUT_W'({hit_y, hit_x});
  assign m_axis_tuser_o = b_status;

endmodule

@@ hw/rtl/sip_checker.sv @@
// ----------------------------------------------------------------------------
// sip_checker
// Port-level checks on the segment intersection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_intersection_point_top_assert.svh"

module sip_checker #(
  parameter int unsigned COORD_BITS = 32
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  input logic [1:0]                        m_axis_tuser_o
);
  import sip_pkg::*;

  // a stalled result must stay offered
  `SIP_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "result dropped while stalled")

  // misses carry a zero point
  `SIP_ASSERT_NOW(a_miss_zero, m_axis_tvalid_o && (m_axis_tuser_o != STATUS_HIT), m_axis_tdata_o == '0, "nonzero point on a miss")

  // only the three defined status codes leave the block
  `SIP_ASSERT_NOW(a_status_code, m_axis_tvalid_o, (m_axis_tuser_o == STATUS_HIT) || (m_axis_tuser_o == STATUS_PARALLEL) || (m_axis_tuser_o == STATUS_OUTSIDE), "undefined status")

  // pipeline is empty right after reset
  `SIP_ASSERT_NOW(a_reset_empty, $rose(rst_ni), !m_axis_tvalid_o, "result valid out of reset")

endmodule

bind segment_intersection_point_top sip_checker #(.COORD_BITS(COORD_BITS)) u_sip_checker (.*);

@@ tb/segment_intersection_point_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point_top_tb
// Self-checking bench for the segment intersection block.
// Sends segment pairs on the slave stream and checks every master stream
// result against an exact wide-integer Cramer solver or a typed row's own
// result. A short table covers the corner cases. Random pairs follow under
// several idle and stall mixes, one long receiver hold-off, one drain pause.
// ----------------------------------------------------------------------------
module segment_intersection_point_top_tb;
  import sip_pkg::*;

  localparam int unsigned CW      = 32;
  localparam int unsigned LATENCY = CW + 10;
  localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] CMIN = 32'sh80000000;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t pair_t [8];

  typedef struct packed {
    status_e        status;
    logic [CW-1:0]  hit_x;
    logic [CW-1:0]  hit_y;
  } point_res_t;

  typedef struct {
    pair_t       seg;
    bit          typed;
    point_res_t  want;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [8*CW-1:0]   s_axis_tdata_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [2*CW-1:0]   m_axis_tdata_o;
  logic [1:0]        m_axis_tuser_o;

  segment_intersection_point_top #(.COORD_BITS(CW)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  point_res_t  pending_points[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          cur_typed = 0;
  point_res_t  cur_want;
  row_t        rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // offset of start along delta by num/det, rounded half away from zero
  function automatic logic [CW-1:0] walk_point(coord_t start, logic signed [127:0] delta,
                                               logic signed [127:0] num,
                                               logic signed [127:0] det);
    logic [127:0] mag, prod, q, r;
    mag  = (delta < 0) ? 128'(-delta) : 128'(delta);
    prod = mag * 128'(num);
    q    = prod / 128'(det);
    r    = prod % 128'(det);
    if ((r << 1) >= 128'(det)) q = q + 1;
    if (delta < 0) q = -q;
    return CW'(128'(start) + q);
  endfunction

  function automatic point_res_t solve_crossing(pair_t s);
    logic signed [127:0] dax, day, dbx, dby, cx, cy, det, rnum, tnum;
    point_res_t res;
    dax  = 128'(s[2]) - 128'(s[0]);
    day  = 128'(s[3]) - 128'(s[1]);
    dbx  = 128'(s[6]) - 128'(s[4]);
    dby  = 128'(s[7]) - 128'(s[5]);
    cx   = 128'(s[4]) - 128'(s[0]);
    cy   = 128'(s[5]) - 128'(s[1]);
    det  = day * dbx - dax * dby;
    rnum = cy * dbx - cx * dby;
    tnum = dax * cy - day * cx;
    res = '{status: STATUS_HIT, hit_x: '0, hit_y: '0};
    if (det == 0) begin
      res.status = STATUS_PARALLEL;
      return res;
    end
    if (det < 0) begin
      det = -det;
      rnum = -rnum;
      tnum = -tnum;
    end
    if (rnum <= 0 || rnum >= det || tnum <= 0 || tnum >= det) begin
      res.status = STATUS_OUTSIDE;
      return res;
    end
    res.hit_x = walk_point(s[0], dax, rnum, det);
    res.hit_y = walk_point(s[1], day, rnum, det);
    return res;
  endfunction

  function automatic pair_t mk(coord_t p0, p1, p2, p3, p4, p5, p6, p7);
    pair_t s;
    s = '{p0, p1, p2, p3, p4, p5, p6, p7};
    return s;
  endfunction

  function automatic coord_t rnd_small();
    return coord_t'($signed($urandom_range(2000)) - 1000);
  endfunction

  function automatic pair_t rnd_pair();
    pair_t s;
    int unsigned kind;
    coord_t dx, dy, mx, my;
    kind = $urandom_range(9);
    for (int i = 0; i < 8; i++) s[i] = coord_t'($urandom());
    case (kind)
      0, 1: ; // full range noise
      2: begin
        for (int i = 0; i < 8; i++) s[i] = rnd_small();
      end
      3: begin
        // parallel or collinear: b direction is a multiple of a direction
        for (int i = 0; i < 4; i++) s[i] = rnd_small();
        s[6] = s[4] + (s[2] - s[0]) * 3;
        s[7] = s[5] + (s[3] - s[1]) * 3;
      end
      4: begin
        // endpoint touch on a or b
        for (int i = 0; i < 8; i++) s[i] = rnd_small();
        if ($urandom_range(1)) begin
          s[4] = s[2];
          s[5] = s[3];
        end else begin
          s[6] = s[0];
          s[7] = s[1];
        end
      end
      default: begin
        // two segments built to pass through a common point
        mx = coord_t'($urandom()) >>> 2;
        my = coord_t'($urandom()) >>> 2;
        dx = coord_t'($urandom()) >>> ($urandom_range(28) + 2);
        dy = coord_t'($urandom()) >>> ($urandom_range(28) + 2);
        s[0] = mx - dx;  s[1] = my - dy;
        s[2] = mx + dx + coord_t'($urandom_range(3));
        s[3] = my + dy;
        dx = coord_t'($urandom()) >>> ($urandom_range(28) + 2);
        dy = coord_t'($urandom()) >>> ($urandom_range(28) + 2);
        s[4] = mx + dy;  s[5] = my - dx;
        s[6] = mx - dy;  s[7] = my + dx + coord_t'($urandom_range(3));
      end
    endcase
    return s;
  endfunction

  task automatic send_pair(pair_t s, bit typed, point_res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= {(8*CW/32){$urandom()}};
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    for (int i = 0; i < 8; i++) s_axis_tdata_i[i*CW +: CW] <= s[i];
    cur_typed <= typed;
    cur_want  <= want;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // receiver ready, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    point_res_t want;
    pair_t s;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      for (int i = 0; i < 8; i++) s[i] = s_axis_tdata_i[i*CW +: CW];
      pending_points.insert(pending_points.size(), cur_typed ? cur_want : solve_crossing(s));
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", m_axis_tuser_o);
      end else begin
        want = pending_points.pop_front();
        if (m_axis_tuser_o !== want.status || m_axis_tdata_o[CW-1:0] !== want.hit_x ||
            m_axis_tdata_o[2*CW-1:CW] !== want.hit_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want st=%0d x=%h y=%h got st=%0d x=%h y=%h", want.status,
                     want.hit_x, want.hit_y, m_axis_tuser_o, m_axis_tdata_o[CW-1:0],
                     m_axis_tdata_o[2*CW-1:CW]);
        end
      end
    end
  end

  task automatic add_row(pair_t s, bit typed, status_e st, coord_t x, coord_t y);
    row_t r;
    r.seg = s;
    r.typed = typed;
    r.want = '{status: st, hit_x: x, hit_y: y};
    rows.insert(rows.size(), r);
  endtask

  initial begin
    point_res_t none;
    int unsigned waited;
    none = '{status: STATUS_HIT, hit_x: '0, hit_y: '0};
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    cur_want = none;

    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1, STATUS_PARALLEL, 0, 0);
    add_row(mk(0, 0, 2, 2, 0, 2, 2, 0), 1, STATUS_HIT, 1, 1);
    add_row(mk(5, 5, 5, 5, 0, 0, 9, 9), 1, STATUS_PARALLEL, 0, 0);       // zero length a
    add_row(mk(0, 0, 4, 4, 0, 3, 4, 0), 0, STATUS_HIT, 0, 0);
    add_row(mk(0, 0, 6, 6, 2, 2, 9, 9), 1, STATUS_PARALLEL, 0, 0);       // collinear overlap
    add_row(mk(0, 0, 2, 0, 2, -1, 2, 1), 1, STATUS_OUTSIDE, 0, 0);       // touch at end of a
    add_row(mk(0, 0, 2, 0, 1, 0, 1, 5), 1, STATUS_OUTSIDE, 0, 0);        // touch at start of b
    add_row(mk(0, 0, 1, 0, 5, -1, 5, 1), 1, STATUS_OUTSIDE, 0, 0);
    add_row(mk(0, 0, 9, 0, 3, 1, 3, 5), 1, STATUS_OUTSIDE, 0, 0);        // t out of range
    add_row(mk(0, 0, 3, 2, 0, 2, 3, 0), 0, STATUS_HIT, 0, 0);            // rounding tie
    add_row(mk(0, 0, -3, -2, 0, -2, -3, 0), 0, STATUS_HIT, 0, 0);        // negative tie
    add_row(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1, STATUS_PARALLEL, 0, 0);
    add_row(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1, STATUS_PARALLEL, 0, 0);
    add_row(mk(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN), 0, STATUS_HIT, 0, 0);
    add_row(mk(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX), 0, STATUS_HIT, 0, 0);
    add_row(mk(CMIN, 0, CMAX, 0, 0, CMIN, 1, CMAX), 0, STATUS_HIT, 0, 0);
    add_row(mk(CMIN, CMAX, CMIN, CMIN, CMAX, 0, CMIN, 1), 0, STATUS_HIT, 0, 0);
    add_row(mk(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX), 0, STATUS_HIT, 0, 0);
    add_row(mk(-1, -1, 1, 1, -1, 1, 1, -1), 1, STATUS_HIT, 0, 0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_pair(rows[i].seg, rows[i].typed, rows[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 23 : 47) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 23 : 47) : 0;
      for (int n = 0; n < 375; n++) begin
        if (phase == 0 && n == 100) hold_left = 300;   // fill the queue, stall input
        if (phase == 2 && n == 200) begin
          // stop offering and let every request drain
          @(negedge clk_i);
          s_axis_tvalid_i <= 1'b0;
          wait (pending_points.size() == 0);
        end
        send_pair(rnd_pair(), 0, none);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    wait (pending_points.size() == 0);
    waited = 0;
    while (waited < 2 * LATENCY) begin
      @(posedge clk_i);
      waited++;
    end

    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sip_pkg.sv
hw/rtl/sip_front.sv
hw/rtl/sip_fifo.sv
hw/rtl/sip_div.sv
hw/rtl/sip_back.sv
hw/rtl/segment_intersection_point_top.sv
hw/rtl/sip_checker.sv
tb/segment_intersection_point_top_tb.sv
